// ===== design/raster_to_tile_4bpp_packer_assert.svh =====
// Assertion macros for the top-level packer file.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef RASTER_TO_TILE_4BPP_PACKER_ASSERT_SVH
`define RASTER_TO_TILE_4BPP_PACKER_ASSERT_SVH

// Same-cycle implication.
`define RTTP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RTTP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/rttp_pkg.sv =====
package rttp_pkg;

	localparam int TILE_EDGE           = 8;
	localparam int MAX_WIDTH_TILES_DEF = 32;
	localparam int CFG_W               = 6;
	localparam int PIX_IN_W            = 8;
	localparam int PIX_W               = 4;
	localparam int BYTE_W              = 8;
	// Wide enough for any active width in tiles and for the tile index plus one.
	localparam int WTILE_W             = 8;

	localparam logic [PIX_IN_W-1:0] REMAP_LOW  = 8'd5;
	localparam logic [PIX_IN_W-1:0] REMAP_CLIP = 8'd16;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_WRITE = 3'b010,
		ST_EMIT  = 3'b100
	} rttp_state_t;

	// Strip store control from the sequencer.
	typedef struct packed {
		logic wr_en;
		logic wr_hi;
		logic rd_en;
	} rttp_mem_ctl_t;

	// Output side control from the sequencer.
	typedef struct packed {
		logic load;
		logic last;
		logic emit_busy;
	} rttp_out_ctl_t;

	function automatic logic [PIX_W-1:0] remap_pixel(input logic [PIX_IN_W-1:0] v);
		logic [PIX_IN_W-1:0] t;
		begin
			t = (v < REMAP_LOW) ? v + 8'd1 : v;
			remap_pixel = (t >= REMAP_CLIP) ? '0 : t[PIX_W-1:0];
		end
	endfunction

endpackage

// ===== design/rttp_store.sv =====
module rttp_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic                   clk,
	input  rttp_pkg::rttp_mem_ctl_t ctl,
	input  logic [AW-1:0]          addr,
	input  logic [3:0]             wdata,
	output logic [7:0]             rdata
);
	import rttp_pkg::*;

	// Even pixels of a pair live in lo_mem, odd pixels in hi_mem, so one read
	// returns a whole output byte.
	logic [PIX_W-1:0] lo_mem [DEPTH];
	logic [PIX_W-1:0] hi_mem [DEPTH];
	logic [PIX_W-1:0] rd_lo_q;
	logic [PIX_W-1:0] rd_hi_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en && !ctl.wr_hi) begin
			lo_mem[addr] <= wdata;
		end
		if (ctl.rd_en) begin
			rd_lo_q <= lo_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_en && ctl.wr_hi) begin
			hi_mem[addr] <= wdata;
		end
		if (ctl.rd_en) begin
			rd_hi_q <= hi_mem[addr];
		end
	end

	assign rdata = {rd_hi_q, rd_lo_q};

endmodule

// ===== design/rttp_seq.sv =====
module rttp_seq #(
	parameter int MAX_WIDTH_TILES = rttp_pkg::MAX_WIDTH_TILES_DEF,
	parameter int AW              = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [rttp_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [rttp_pkg::PIX_IN_W-1:0] in_data,
	input  logic                          out_free,
	output rttp_pkg::rttp_mem_ctl_t       mem_ctl,
	output logic [AW-1:0]                 mem_addr,
	output logic [rttp_pkg::PIX_W-1:0]    mem_wdata,
	output rttp_pkg::rttp_out_ctl_t       out_ctl
);
	import rttp_pkg::*;

	localparam int HALF_ROW  = MAX_WIDTH_TILES * TILE_EDGE / 2;
	localparam int TW        = (MAX_WIDTH_TILES > 1) ? $clog2(MAX_WIDTH_TILES) : 1;
	localparam int LAST_BYTE = TILE_EDGE * TILE_EDGE / 2 - 1;

	rttp_state_t       state_q;
	logic [CFG_W-1:0]  width_q;
	logic [TW-1:0]     tile_q;
	logic [2:0]        sub_q;
	logic [2:0]        row_q;
	logic              trig_q;
	logic [4:0]        cnt_q;
	logic              rd_vld_s1;
	logic              rd_last_s1;

	logic [PIX_W-1:0]  pix_q;
	logic [2:0]        wr_row_q;
	logic [TW-1:0]     wr_tile_q;
	logic [2:0]        wr_sub_q;

	logic              accept;
	logic [WTILE_W-1:0] w_act;
	logic [WTILE_W-1:0] t1;
	logic              row_end;
	logic              trig;
	logic              load;
	logic              rd_en;
	logic [2:0]        a_row;
	logic [TW+1:0]     a_pair;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		if (width_q == '0) begin
			w_act = WTILE_W'(1);
		end else if (WTILE_W'(width_q) > WTILE_W'(MAX_WIDTH_TILES)) begin
			w_act = WTILE_W'(MAX_WIDTH_TILES);
		end else begin
			w_act = WTILE_W'(width_q);
		end
	end

	// The row ends once the column reaches the last pixel of the current width,
	// or has already passed it after a width change.
	assign t1      = WTILE_W'(tile_q) + WTILE_W'(1);
	assign row_end = (t1 > w_act) || ((t1 == w_act) && (sub_q == 3'd7));
	assign trig    = (row_q == 3'd7) && (sub_q == 3'd7);

	assign load  = rd_vld_s1 && out_free;
	assign rd_en = (state_q == ST_EMIT) && (!rd_vld_s1 || load);

	// One address unit serves the pixel write and the 32 tile reads.
	always_comb begin
		if (state_q == ST_EMIT) begin
			a_row  = cnt_q[4:2];
			a_pair = {wr_tile_q, cnt_q[1:0]};
		end else begin
			a_row  = wr_row_q;
			a_pair = {wr_tile_q, wr_sub_q[2:1]};
		end
	end

	assign mem_addr = AW'(a_row) * AW'(HALF_ROW) + AW'(a_pair);

	assign mem_ctl.wr_en = (state_q == ST_WRITE);
	assign mem_ctl.wr_hi = wr_sub_q[0];
	assign mem_ctl.rd_en = rd_en;
	assign mem_wdata     = pix_q;

	assign out_ctl.load      = load;
	assign out_ctl.last      = rd_last_s1;
	assign out_ctl.emit_busy = (state_q == ST_EMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CFG_W'(1);
		end else if (cfg_wen) begin
			width_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_q <= '0;
			sub_q  <= '0;
			row_q  <= '0;
			trig_q <= 1'b0;
		end else if (accept) begin
			trig_q <= trig;
			if (row_end) begin
				tile_q <= '0;
				sub_q  <= '0;
				row_q  <= row_q + 3'd1;
			end else if (sub_q == 3'd7) begin
				tile_q <= tile_q + TW'(1);
				sub_q  <= '0;
			end else begin
				sub_q <= sub_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q     <= remap_pixel(in_data);
			wr_row_q  <= row_q;
			wr_tile_q <= tile_q;
			wr_sub_q  <= sub_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					cnt_q   <= '0;
					state_q <= trig_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (rd_en) begin
						cnt_q <= cnt_q + 5'd1;
						if (cnt_q == 5'(LAST_BYTE)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
		end else if (rd_en) begin
			rd_vld_s1  <= 1'b1;
			rd_last_s1 <= (cnt_q == 5'(LAST_BYTE));
		end else if (load) begin
			rd_vld_s1 <= 1'b0;
		end
	end

endmodule

// ===== design/raster_to_tile_4bpp_packer.sv =====
// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tdata[7:0] = pixel_value
// m_axis    out        tdata[7:0] = packed_byte, tlast = tile_last
// cfg       in         cfg_wdata[5:0] = width_in_tiles, written when cfg_wen is high
//
// Each pixel is accepted in ST_IDLE and then written to the strip store in ST_WRITE.
// A pixel that completes a tile then sends its 32 bytes, one byte per cycle through the
// store's single read port; a stall on m_axis holds the reads back.
// The output register lets a finished byte wait while the next pixel is taken.
// Reset clears the counters and sets the width to one tile; the store is not cleared.
`include "raster_to_tile_4bpp_packer_assert.svh"

module raster_to_tile_4bpp_packer #(
	parameter int MAX_WIDTH_TILES = rttp_pkg::MAX_WIDTH_TILES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wen,
	input  logic [rttp_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [rttp_pkg::PIX_IN_W-1:0] s_axis_tdata,   // [7:0] pixel_value
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [rttp_pkg::BYTE_W-1:0]   m_axis_tdata,   // [7:0] packed_byte
	output logic                          m_axis_tlast
);
	import rttp_pkg::*;

	localparam int DEPTH = TILE_EDGE * MAX_WIDTH_TILES * TILE_EDGE / 2;
	localparam int AW    = $clog2(DEPTH);

	rttp_mem_ctl_t     mem_ctl;
	rttp_out_ctl_t     out_ctl;
	logic [AW-1:0]     mem_addr;
	logic [PIX_W-1:0]  mem_wdata;
	logic [BYTE_W-1:0] rdata;
	logic              out_free;
	logic              tvalid_q;
	logic              tlast_q;
	logic [BYTE_W-1:0] tdata_q;
	logic              in_req;

	rttp_seq #(
		.MAX_WIDTH_TILES(MAX_WIDTH_TILES),
		.AW             (AW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_data  (s_axis_tdata),
		.out_free (out_free),
		.mem_ctl  (mem_ctl),
		.mem_addr (mem_addr),
		.mem_wdata(mem_wdata),
		.out_ctl  (out_ctl)
	);

	rttp_store #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_store (
		.clk  (clk),
		.ctl  (mem_ctl),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(rdata)
	);

	assign out_free = !tvalid_q || m_axis_tready;
	assign in_req   = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (out_ctl.load) begin
			tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ctl.load) begin
			tdata_q <= rdata;
			tlast_q <= out_ctl.last;
		end
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tlast  = tlast_q;

	`RTTP_ASSERT_NEXT(a_busy_after_req, in_req, !s_axis_tready, "ready after a request")
	`RTTP_ASSERT_IMP(a_load_ok, out_ctl.load, !m_axis_tvalid || m_axis_tready, "byte overwritten")
	`RTTP_ASSERT_IMP(a_valid_src, $rose(m_axis_tvalid), $past(out_ctl.load), "valid without read")
	`RTTP_ASSERT_IMP(a_emit_busy, out_ctl.emit_busy, !s_axis_tready, "ready while emitting")

endmodule
